/* design/rsfh_pkg.sv */
// ============================================================================
// rsfh_pkg
// Shared widths, register indexes and payload types of the ray/sphere
// first-hit pipeline.
// ============================================================================
package rsfh_pkg;

  // field widths
  localparam int COORD_WIDTH  = 32;
  localparam int DIR_WIDTH    = 16;
  localparam int RADIUS_WIDTH = COORD_WIDTH - 1;
  localparam int TOL_WIDTH    = 16;

  // internal fixed-point formats
  localparam int UNIT_FRAC = 30;  // unit direction fraction bits
  localparam int LEN_EXTRA = 15;  // extra fraction bits of the length root

  // configuration port
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = COORD_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Z  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE = 3'd4;

  // derived datapath widths
  localparam int VEC_W   = COORD_WIDTH + 1;              // origin - center
  localparam int N2_W    = 2 * DIR_WIDTH;                // |d|^2
  localparam int SQ1_XW  = N2_W + 2 * LEN_EXTRA;         // length root operand
  localparam int LEN_W   = SQ1_XW / 2;                   // length root
  localparam int NUM_W   = DIR_WIDTH + UNIT_FRAC + LEN_EXTRA + 1;
  localparam int QUO_W   = UNIT_FRAC + 2;                // unit component magnitude
  localparam int UNIT_W  = QUO_W + 1;                    // signed unit component
  localparam int PROD_W  = VEC_W + UNIT_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int RR_W    = 2 * RADIUS_WIDTH;
  localparam int P_W     = SUM_W - UNIT_FRAC;            // projection
  localparam int PP_W    = 2 * P_W;
  localparam int DQ_W    = PP_W + 1;                     // quarter discriminant
  localparam int SQ2_XW  = 2 * (VEC_W);                  // discriminant root operand
  localparam int ROOT2_W = SQ2_XW / 2;
  localparam int T_W     = P_W + 1;                      // ray parameter
  localparam int M_W     = UNIT_W + T_W;
  localparam int H_W     = M_W - UNIT_FRAC + 1;          // unsaturated point

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [DIR_WIDTH-1:0]   dir_x;
    logic signed [DIR_WIDTH-1:0]   dir_y;
    logic signed [DIR_WIDTH-1:0]   dir_z;
  } ray_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] hit_x;
    logic signed [COORD_WIDTH-1:0] hit_y;
    logic signed [COORD_WIDTH-1:0] hit_z;
  } hit_t;

endpackage

/* design/rsfh_isqrt.sv */
// ============================================================================
// rsfh_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ============================================================================
module rsfh_isqrt import rsfh_pkg::*; #(
  parameter int XW     = SQ1_XW,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [XW-1:0]     in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [XW/2-1:0]   out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int RW    = XW / 2;
  localparam int REM_W = RW + 2;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [RW-1:0]    root;
    logic [XW-1:0]    x;
  } sq_st_t;

  // one digit-recurrence step: bring in two operand bits, try root bit 1
  function automatic sq_st_t sq_step(input sq_st_t s);
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] tr;
    sq_st_t           r;
    rs  = {s.rem[REM_W-3:0], s.x[XW-1 -: 2]};
    tr  = {s.root, 2'b01};
    r.x = {s.x[XW-3:0], 2'b00};
    if (rs >= tr) begin
      r.rem  = rs - tr;
      r.root = {s.root[RW-2:0], 1'b1};
    end else begin
      r.rem  = rs;
      r.root = {s.root[RW-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [RW-1:0]     vld;
  sq_st_t            st   [RW];
  sq_st_t            st_next [RW];
  logic [SIDE_W-1:0] side [RW];
  sq_st_t            st_in;

  // stage logic
  always_comb begin
    st_in.rem  = '0;
    st_in.root = '0;
    st_in.x    = in_x;
    st_next[0] = sq_step(st_in);
    for (int k = 1; k < RW; k++) begin
      st_next[k] = sq_step(st[k-1]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RW-2:0], in_valid};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int k = 0; k < RW; k++) begin
        st[k] <= st_next[k];
      end
      for (int k = 1; k < RW; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = st[RW-1].root;
  assign out_side  = side[RW-1];

endmodule

/* design/rsfh_div.sv */
// ============================================================================
// rsfh_div
// Pipelined restoring divider, several numerators over one divisor,
// one quotient bit per stage, with sideband.
// ============================================================================
module rsfh_div import rsfh_pkg::*; #(
  parameter int LANES  = 3,
  parameter int NW     = NUM_W,
  parameter int DW     = LEN_W,
  parameter int QW     = QUO_W,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [LANES-1:0][NW-1:0] in_num,
  input  logic [DW-1:0]            in_div,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [LANES-1:0][QW-1:0] out_q,
  output logic [SIDE_W-1:0]        out_side
);

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] q;
  } dv_st_t;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic dv_st_t dv_step(input dv_st_t s, input logic [DW-1:0] dv);
    logic [DW:0] rs;
    dv_st_t      r;
    rs    = {s.rem, s.low[QW-1]};
    r.low = {s.low[QW-2:0], 1'b0};
    if (rs >= {1'b0, dv}) begin
      r.rem = DW'(rs - {1'b0, dv});
      r.q   = {s.q[QW-2:0], 1'b1};
    end else begin
      r.rem = rs[DW-1:0];
      r.q   = {s.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [QW-1:0]     vld;
  dv_st_t            st      [QW][LANES];
  dv_st_t            st_next [QW][LANES];
  logic [DW-1:0]     dv      [QW];
  logic [SIDE_W-1:0] side    [QW];
  dv_st_t            st_in   [LANES];

  // stage logic; upper numerator bits seed the partial remainder
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      st_in[l].rem  = DW'(in_num[l][NW-1:QW]);
      st_in[l].low  = in_num[l][QW-1:0];
      st_in[l].q    = '0;
      st_next[0][l] = dv_step(st_in[l], in_div);
      for (int k = 1; k < QW; k++) begin
        st_next[k][l] = dv_step(st[k-1][l], dv[k-1]);
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      dv[0]   <= in_div;
      side[0] <= in_side;
      for (int k = 1; k < QW; k++) begin
        dv[k]   <= dv[k-1];
        side[k] <= side[k-1];
      end
      for (int k = 0; k < QW; k++) begin
        for (int l = 0; l < LANES; l++) begin
          st[k][l] <= st_next[k][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_q[l] = st[QW-1][l].q;
    end
  end

  assign out_valid = vld[QW-1];
  assign out_side  = side[QW-1];

endmodule

/* design/ray_sphere_first_hit.sv */
// ============================================================================
// ray_sphere_first_hit
// Nearer meeting point of a ray line with a register-held sphere.
// ============================================================================
//  channel   direction  payload  handshake
//  in        input      ray_t    in_valid / in_stall
//  out       output     hit_t    out_valid / out_stall
//  cfg       input      index    cfg_we, cfg_index, cfg_data
//
// One ray enters per cycle while in_stall is low; the pipeline holds the two
// root pipelines (31 and 33 stages) and the 32-stage unit-vector divider.
// Synchronous reset empties the pipeline and loads register defaults.
// When a result is held on a stall the whole pipeline freezes and in_stall
// is raised; nothing is dropped or repeated.
module ray_sphere_first_hit import rsfh_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ray_t                       in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output hit_t                       out_data,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] o;
    logic [2:0][DIR_WIDTH-1:0]   d;
    logic [2:0][VEC_W-1:0]       v;
    logic                        zero;
  } s1_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] o;
    logic [2:0][UNIT_W-1:0]      u;
    logic                        miss;
  } s2_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] o;
    logic [2:0][UNIT_W-1:0]      u;
    logic [P_W-1:0]              p;
    logic                        miss;
    logic                        tangent;
  } s4_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] o;
    logic                        miss;
  } s6_t;

  localparam logic signed [H_W-1:0] HMAX =
    {{(H_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [H_W-1:0] HMIN = ~HMAX;

  logic en;

  // configuration registers
  logic signed [COORD_WIDTH-1:0] ctr [3];
  logic [RADIUS_WIDTH-1:0]       rad;
  logic [TOL_WIDTH-1:0]          tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr[0] <= '0;
      ctr[1] <= '0;
      ctr[2] <= '0;
      rad    <= '0;
      tol    <= TOL_WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:  ctr[0] <= cfg_data[COORD_WIDTH-1:0];
        REG_CENTER_Y:  ctr[1] <= cfg_data[COORD_WIDTH-1:0];
        REG_CENTER_Z:  ctr[2] <= cfg_data[COORD_WIDTH-1:0];
        REG_RADIUS:    rad    <= cfg_data[RADIUS_WIDTH-1:0];
        REG_TOLERANCE: tol    <= cfg_data[TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------------------------------------------------------- stage A
  // offset from center and squared direction length
  logic          a_vld;
  s1_t           a_s, a_s_next;
  logic [N2_W-1:0] a_n2, a_n2_next;

  always_comb begin
    logic signed [N2_W-1:0] sq;
    a_s_next.o[0] = in_data.origin_x;
    a_s_next.o[1] = in_data.origin_y;
    a_s_next.o[2] = in_data.origin_z;
    a_s_next.d[0] = in_data.dir_x;
    a_s_next.d[1] = in_data.dir_y;
    a_s_next.d[2] = in_data.dir_z;
    a_n2_next = '0;
    for (int i = 0; i < 3; i++) begin
      a_s_next.v[i] = VEC_W'($signed(a_s_next.o[i])) - VEC_W'(ctr[i]);
      sq = $signed(a_s_next.d[i]) * $signed(a_s_next.d[i]);
      a_n2_next = a_n2_next + N2_W'(sq);
    end
    a_s_next.zero = (a_n2_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s  <= a_s_next;
      a_n2 <= a_n2_next;
    end
  end

  // direction length, scaled by 2^LEN_EXTRA
  logic             q1_vld;
  logic [LEN_W-1:0] q1_len;
  s1_t              q1_s;

  rsfh_isqrt #(.XW(SQ1_XW), .SIDE_W($bits(s1_t))) u_len_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (a_vld),
    .in_x     ({a_n2, {(2*LEN_EXTRA){1'b0}}}),
    .in_side  (a_s),
    .out_valid(q1_vld),
    .out_root (q1_len),
    .out_side (q1_s)
  );

  // ---------------------------------------------------------------- stage B
  // rounded numerators for the unit components
  logic                     b_vld;
  logic [2:0][NUM_W-1:0]    b_num, b_num_next;
  logic [LEN_W-1:0]         b_len;
  s1_t                      b_s;

  always_comb begin
    logic [DIR_WIDTH-1:0] mag;
    for (int l = 0; l < 3; l++) begin
      mag = q1_s.d[l][DIR_WIDTH-1] ? (~q1_s.d[l] + 1'b1) : q1_s.d[l];
      b_num_next[l] = (NUM_W'(mag) << (UNIT_FRAC + LEN_EXTRA)) + NUM_W'(q1_len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= q1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_num <= b_num_next;
      b_len <= q1_len;
      b_s   <= q1_s;
    end
  end

  logic                  dv_vld;
  logic [2:0][QUO_W-1:0] dv_q;
  s1_t                   dv_s;

  rsfh_div #(
    .LANES(3), .NW(NUM_W), .DW(LEN_W), .QW(QUO_W), .SIDE_W($bits(s1_t))
  ) u_unit_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (b_vld),
    .in_num   (b_num),
    .in_div   (b_len),
    .in_side  (b_s),
    .out_valid(dv_vld),
    .out_q    (dv_q),
    .out_side (dv_s)
  );

  // ---------------------------------------------------------------- stage C
  // signed unit vector, products v*v and u*v, radius squared
  logic                   c_vld;
  logic [2:0][PROD_W-1:0] c_vv, c_vv_next, c_uv, c_uv_next;
  logic [RR_W-1:0]        c_rr;
  s2_t                    c_s, c_s_next;

  always_comb begin
    logic signed [UNIT_W-1:0] uu;
    logic signed [VEC_W-1:0]  vs;
    logic signed [PROD_W-1:0] pv;
    logic signed [PROD_W-1:0] pu;
    c_s_next.o    = dv_s.o;
    c_s_next.miss = dv_s.zero;
    for (int l = 0; l < 3; l++) begin
      uu = dv_s.d[l][DIR_WIDTH-1] ? -$signed({1'b0, dv_q[l]}) : $signed({1'b0, dv_q[l]});
      vs = $signed(dv_s.v[l]);
      pv = vs * vs;
      pu = uu * vs;
      c_s_next.u[l] = uu;
      c_vv_next[l]  = pv;
      c_uv_next[l]  = pu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_vv <= c_vv_next;
      c_uv <= c_uv_next;
      c_rr <= RR_W'(rad) * RR_W'(rad);
      c_s  <= c_s_next;
    end
  end

  // ---------------------------------------------------------------- stage D
  // |v|^2, inside test, rounded projection p
  logic                    d_vld;
  logic signed [SUM_W-1:0] d_vv, d_vv_next;
  logic [RR_W-1:0]         d_rr;
  logic signed [P_W-1:0]   d_p, d_p_next;
  s2_t                     d_s, d_s_next;

  always_comb begin
    logic signed [SUM_W-1:0] accs;
    logic [SUM_W-1:0]        rnd;
    d_vv_next = '0;
    accs      = '0;
    for (int l = 0; l < 3; l++) begin
      d_vv_next = d_vv_next + $signed(c_vv[l]);
      accs      = accs + $signed(c_uv[l]);
    end
    rnd      = accs + (SUM_W'(1) << (UNIT_FRAC - 1));
    d_p_next = rnd[SUM_W-1:UNIT_FRAC];
    d_s_next = c_s;
    // on or inside the sphere counts as a miss
    if (!($signed({{(SUM_W-RR_W){1'b0}}, c_rr}) < d_vv_next)) begin
      d_s_next.miss = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_vv <= d_vv_next;
      d_rr <= c_rr;
      d_p  <= d_p_next;
      d_s  <= d_s_next;
    end
  end

  // ---------------------------------------------------------------- stage E
  // p squared
  logic                   e_vld;
  logic signed [PP_W-1:0] e_pp;
  logic signed [SUM_W-1:0] e_vv;
  logic [RR_W-1:0]        e_rr;
  logic signed [P_W-1:0]  e_p;
  s2_t                    e_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_pp <= d_p * d_p;
      e_vv <= d_vv;
      e_rr <= d_rr;
      e_p  <= d_p;
      e_s  <= d_s;
    end
  end

  // ---------------------------------------------------------------- stage F
  // quarter discriminant, sign and tangent tests
  logic              f_vld;
  logic [SQ2_XW-1:0] f_x;
  s4_t               f_s, f_s_next;
  logic signed [DQ_W-1:0] dq;

  always_comb begin
    dq = e_pp + $signed({1'b0, e_rr}) - e_vv;
    f_s_next.o       = e_s.o;
    f_s_next.u       = e_s.u;
    f_s_next.p       = e_p;
    f_s_next.miss    = e_s.miss || dq[DQ_W-1];
    f_s_next.tangent = {dq, 2'b00} < (DQ_W + 2)'(tol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_x <= dq[SQ2_XW-1:0];
      f_s <= f_s_next;
    end
  end

  logic               q2_vld;
  logic [ROOT2_W-1:0] q2_s;
  s4_t                q2_side;

  rsfh_isqrt #(.XW(SQ2_XW), .SIDE_W($bits(s4_t))) u_disc_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_vld),
    .in_x     (f_x),
    .in_side  (f_s),
    .out_valid(q2_vld),
    .out_root (q2_s),
    .out_side (q2_side)
  );

  // ---------------------------------------------------------------- stage G
  // ray parameter: tangent point, else root of smaller magnitude
  logic                  g_vld;
  logic signed [T_W-1:0] g_t, g_t_next;
  s2_t                   g_s;

  always_comb begin
    logic signed [T_W-1:0] np;
    logic signed [T_W-1:0] sr;
    np = -T_W'($signed(q2_side.p));
    sr = T_W'($signed({1'b0, q2_s}));
    if (q2_side.tangent) begin
      g_t_next = np;
    end else if (q2_side.p[P_W-1]) begin
      g_t_next = np - sr;
    end else begin
      g_t_next = np + sr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= q2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_t      <= g_t_next;
      g_s.o    <= q2_side.o;
      g_s.u    <= q2_side.u;
      g_s.miss <= q2_side.miss;
    end
  end

  // ---------------------------------------------------------------- stage H
  // offsets along the unit direction
  logic                h_vld;
  logic [2:0][M_W-1:0] h_m, h_m_next;
  s6_t                 h_s;

  always_comb begin
    logic signed [M_W-1:0] pm;
    for (int l = 0; l < 3; l++) begin
      pm = $signed(g_s.u[l]) * g_t;
      h_m_next[l] = pm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (en) begin
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_m      <= h_m_next;
      h_s.o    <= g_s.o;
      h_s.miss <= g_s.miss;
    end
  end

  // ---------------------------------------------------------------- output
  // round, add to origin, saturate; zeros on a miss
  hit_t out_next;

  always_comb begin
    logic [M_W-1:0]        ms;
    logic signed [H_W-1:0] hv;
    logic [2:0][COORD_WIDTH-1:0] pt;
    for (int l = 0; l < 3; l++) begin
      ms = h_m[l] + (M_W'(1) << (UNIT_FRAC - 1));
      hv = H_W'($signed(h_s.o[l])) + H_W'($signed(ms[M_W-1:UNIT_FRAC]));
      if (hv > HMAX) begin
        hv = HMAX;
      end else if (hv < HMIN) begin
        hv = HMIN;
      end
      pt[l] = h_s.miss ? '0 : hv[COORD_WIDTH-1:0];
    end
    out_next.hit   = !h_s.miss;
    out_next.hit_x = pt[0];
    out_next.hit_y = pt[1];
    out_next.hit_z = pt[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

`ifndef SYNTHESIS
  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |->
      (out_data.hit_x == '0 && out_data.hit_y == '0 && out_data.hit_z == '0))
    else $error("miss with nonzero point");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  // a held result freezes the pipe and keeps the input stalled
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && (in_stall || !out_stall)))
    else $error("held result lost");

  // register defaults after reset
  a_cfg_reset: assert property (@(posedge clk)
    rst |=> (tol == TOL_WIDTH'(1) && rad == '0))
    else $error("bad register defaults");
`endif

endmodule

/* tb/sv/tb_ray_sphere_first_hit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_sphere_first_hit
// Self-checking bench for the ray/sphere first-hit pipeline. Rays are queued
// by the stimulus process, sent by a clocked driver with random gaps, and each
// transfer is predicted with exact wide integer math. A clocked monitor
// checks every hit record against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ray_sphere_first_hit;
  import rsfh_pkg::*;

  localparam int  DRAIN_CYCLES = 140;
  localparam int  LONG_HOLD    = 400;
  localparam int  CYCLE_LIMIT  = 600000;
  localparam logic signed [127:0] HALF30 = 128'sd536870912;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  ray_t                       in_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  hit_t                       out_data;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  // sphere registers as the bench believes them to be
  longint    sph_center [3];
  longint    sph_radius;
  longint    sph_tol;

  ray_t      pending_rays [$];
  hit_t      expected_hits [$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      hold_request = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;
  int        mismatches = 0;
  int        cycles = 0;

  always #5 clk = ~clk;

  ray_sphere_first_hit uut (.*);

  // integer square root of an unsigned 128-bit value
  function automatic logic [63:0] root128(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (x >= {64'd0, c} * {64'd0, c}) r = c;
    end
    return r;
  endfunction

  // nearer meeting point of one ray with the current sphere
  function automatic hit_t first_hit(ray_t ray);
    longint                 o [3];
    longint                 d [3];
    logic signed [127:0]    u [3];
    logic signed [127:0]    v [3];
    logic signed [127:0]    vv, acc, rr, pw, dq, m;
    longint unsigned        n2, lens, q, mag;
    longint                 p, s, t, h;
    logic [127:0]           disc;
    hit_t                   res;
    res = '0;
    o[0] = ray.origin_x; o[1] = ray.origin_y; o[2] = ray.origin_z;
    d[0] = ray.dir_x;    d[1] = ray.dir_y;    d[2] = ray.dir_z;
    n2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    if (n2 == 0) return res;
    lens = root128({64'd0, n2 << 30});
    vv = '0;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      mag = (d[i] < 0) ? -d[i] : d[i];
      q = ((mag << 45) + lens / 2) / lens;
      u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
      v[i] = o[i];
      v[i] = v[i] - sph_center[i];
      vv = vv + v[i] * v[i];
      acc = acc + u[i] * v[i];
    end
    rr = sph_radius;
    rr = rr * rr;
    // origin inside or on the sphere
    if (!(rr < vv)) return res;
    pw = (acc + HALF30) >>> 30;
    p = pw[63:0];
    pw = p;
    dq = pw * pw + rr - vv;
    if (dq < 0) return res;
    disc = dq << 2;
    if (disc < {112'd0, 16'(sph_tol)}) begin
      t = -p;
    end else begin
      s = root128(dq);
      t = (p < 0) ? -p - s : -p + s;
    end
    res.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      m = t;
      m = (u[i] * m + HALF30) >>> 30;
      h = o[i] + longint'(m[63:0]);
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      case (i)
        0: res.hit_x = h[31:0];
        1: res.hit_y = h[31:0];
        default: res.hit_z = h[31:0];
      endcase
    end
    return res;
  endfunction

  // ray driver: one transfer per accepted cycle, random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_hits.push_back(first_hit(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_rays.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // hit monitor and output stall
  always @(posedge clk) begin
    hit_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected hit record %p", out_data);
        end else begin
          want = expected_hits.pop_front();
          if (out_data.hit !== want.hit || out_data.hit_x !== want.hit_x ||
              out_data.hit_y !== want.hit_y || out_data.hit_z !== want.hit_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("hit mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      // one long hold-off so the pipeline fills and backs up
      if (hold_request && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** ray_sphere_first_hit: FAILED **");
      $finish;
    end
  end

  // register write; caller lowers cfg_we afterwards
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, longint value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[31:0];
    case (idx)
      REG_CENTER_X:  sph_center[0] = longint'(signed'(value[31:0]));
      REG_CENTER_Y:  sph_center[1] = longint'(signed'(value[31:0]));
      REG_CENTER_Z:  sph_center[2] = longint'(signed'(value[31:0]));
      REG_RADIUS:    sph_radius = value[30:0];
      REG_TOLERANCE: sph_tol = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(longint cx, longint cy, longint cz, longint r, longint tol);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
    write_reg(REG_TOLERANCE, tol);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_rays.size() == 0 && !in_valid && expected_hits.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic ray_t mk_ray(longint ox, longint oy, longint oz,
                                  longint dx, longint dy, longint dz);
    ray_t r;
    r.origin_x = ox[31:0]; r.origin_y = oy[31:0]; r.origin_z = oz[31:0];
    r.dir_x = dx[15:0];    r.dir_y = dy[15:0];    r.dir_z = dz[15:0];
    return r;
  endfunction

  // mostly rays aimed near the sphere, some tangent, some pure noise
  function automatic ray_t random_ray();
    longint off [3];
    longint dir [3];
    longint big, scale, span;
    ray_t   r;
    if ($urandom_range(9) == 0) begin
      r = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
      return r;
    end
    span = (sph_radius < 64) ? 256 : sph_radius * 4;
    if (span > 64'd1000000000) span = 64'd1000000000;
    if ($urandom_range(7) == 0) begin
      // tangent line: passes at exactly one radius from the center
      r = mk_ray(sph_center[0] - longint'($urandom_range(32'(span))),
                 sph_center[1] + sph_radius, sph_center[2],
                 $urandom_range(1, 32767), 0, 0);
      return r;
    end
    big = 1;
    for (int i = 0; i < 3; i++) begin
      off[i] = longint'($urandom_range(32'(2 * span))) - span;
      if ((off[i] < 0 ? -off[i] : off[i]) > big) big = (off[i] < 0) ? -off[i] : off[i];
    end
    scale = big / 12000 + 1;
    for (int i = 0; i < 3; i++)
      dir[i] = -off[i] / scale + longint'($urandom_range(4000)) - 2000;
    return mk_ray(sph_center[0] + off[0], sph_center[1] + off[1], sph_center[2] + off[2],
                  dir[0], dir[1], dir[2]);
  endfunction

  task automatic run_random(int count);
    repeat (count) pending_rays.push_back(random_ray());
    wait_drained();
  endtask

  // stimulus and phase control
  initial begin
    sph_center[0] = 0; sph_center[1] = 0; sph_center[2] = 0;
    sph_radius = 0;
    sph_tol = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // default registers: zero sphere, zero direction, extremes
    pending_rays.push_back(mk_ray(256, 0, 0, 0, 0, 0));
    pending_rays.push_back(mk_ray(0, 0, 0, 16384, 0, 0));
    pending_rays.push_back(mk_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                                  32767, 32767, 32767));
    pending_rays.push_back(mk_ray(2147483647, 2147483647, 2147483647, -32768, -32768, -32768));
    wait_drained();

    set_sphere(0, 0, 0, 2560, 1);
    // straight in, straight away (behind), inside, on surface, tangent
    pending_rays.push_back(mk_ray(-25600, 0, 0, 16384, 0, 0));
    pending_rays.push_back(mk_ray(-25600, 0, 0, -16384, 0, 0));
    pending_rays.push_back(mk_ray(100, 100, 100, 0, 16384, 0));
    pending_rays.push_back(mk_ray(2560, 0, 0, 16384, 0, 0));
    pending_rays.push_back(mk_ray(-25600, 2560, 0, 16384, 0, 0));
    pending_rays.push_back(mk_ray(-25600, 2561, 0, 16384, 0, 0));
    pending_rays.push_back(mk_ray(0, 0, -99999, -1, 0, 32767));
    pending_rays.push_back(mk_ray(0, 0, -99999, 1, 1, 1));
    pending_rays.push_back(mk_ray(0, 25600, 0, 0, -32768, 0));
    wait_drained();

    // wide tolerance turns near misses into tangent points
    set_sphere(-51200, 76800, 12800, 6400, 65535);
    pending_rays.push_back(mk_ray(-51200 - 40000, 76800 + 6400, 12800, 16384, 0, 0));
    pending_rays.push_back(mk_ray(-51200 - 40000, 76800 + 6399, 12800, 16384, 2, 0));
    pending_rays.push_back(mk_ray(-51200, 76800, 12800 + 90000, 5, -7, -16384));
    wait_drained();

    // sender rarely idle, receiver mostly stalled; long back-pressure hold
    send_idle_pct = 14;
    recv_idle_pct = 73;
    set_sphere(300000, -200000, 12345, 40000, 1000);
    hold_request = 1'b1;
    run_random(500);

    // roles swapped, coordinate extremes in the registers
    send_idle_pct = 73;
    recv_idle_pct = 14;
    set_sphere(2147483647, -64'sd2147483648, 0, 2147483647, 0);
    run_random(150);
    set_sphere(-1000, 1000, -777, 1, 65535);
    run_random(200);

    // full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sphere(-64'sd2147483648, 2147483647, -64'sd2147483648, 1000000, 3);
    run_random(150);
    set_sphere(5000, 5000, 5000, 200000, 0);
    run_random(500);

    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("** ray_sphere_first_hit: PASSED **");
    end else begin
      $display("** ray_sphere_first_hit: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
design/rsfh_pkg.sv
design/rsfh_isqrt.sv
design/rsfh_div.sv
design/ray_sphere_first_hit.sv
tb/sv/tb_ray_sphere_first_hit.sv
